// ===== hw/rtl/fra_pkg.sv =====
// fra_pkg: shared types and codes for the fenced ring allocator
// no dependencies
package fra_pkg;
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_RECLAIM = 2'd2;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOROOM = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [4:0] MAX_ALIGN_LOG2 = 5'd16;

    typedef struct packed {
        logic [1:0]  command;
        logic        bad;
        logic [29:0] size;
        logic [4:0]  align_log2;
        logic [47:0] completed;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [28:0] offset;
        logic [29:0] occupied;
        logic [47:0] stamped;
        logic [29:0] used;
    } res_t;
endpackage

// ===== hw/rtl/fra_front.sv =====
// fra_front: accepts transactions, flags invalid commands, queues them
// depends on fra_pkg
module fra_front #(
    parameter int QDEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           command,
    input  logic [29:0]          request_size,
    input  logic [4:0]           align_log2,
    input  logic [47:0]          completed_fence,
    output logic                 q_valid,
    input  logic                 q_ready,
    output fra_pkg::cmd_t        q_data
);
    import fra_pkg::*;
    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    cmd_t        mem_reg [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;
    cmd_t        c;
    logic        push, pop;

    always_comb begin
        c.command = command;
        c.size = request_size;
        c.align_log2 = align_log2;
        c.completed = completed_fence;
        c.bad = (command == CMD_ALLOC) ?
                (request_size == 30'd0 || align_log2 > MAX_ALIGN_LOG2) :
                !(command == CMD_FLUSH || command == CMD_RECLAIM);
    end

    assign s_ready = (cnt_reg != (AW+1)'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = mem_reg[rp_reg];
    assign push = s_valid && s_ready;
    assign pop  = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= c;
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == AW'(QDEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop)  rp_reg <= (rp_reg == AW'(QDEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ===== hw/rtl/fra_back.sv =====
// fra_back: executes allocate, stamp and reclaim against the tracking queue
// depends on fra_pkg
module fra_back #(
    parameter int TRACK_DEPTH = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic          cfg_idx,
    input  logic [29:0]   cfg_data,
    input  logic          q_valid,
    output logic          q_ready,
    input  fra_pkg::cmd_t q_data,
    output logic          r_valid,
    input  logic          r_ready,
    output fra_pkg::res_t r_data
);
    import fra_pkg::*;
    localparam int AW = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
    localparam int CW = AW + 1;
    localparam logic [2:0] S_IDLE = 3'd0, S_CALC = 3'd1, S_DEC = 3'd2,
                           S_STAMP = 3'd3, S_RECL = 3'd4, S_RDAT = 3'd5,
                           S_OUT = 3'd6;

    logic [2:0]  state_reg;
    logic [29:0] cap_reg, thr_reg;
    logic [29:0] cursor_reg, used_reg;
    logic [30:0] batch_reg;
    logic [47:0] fence_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg, unst_reg;
    logic [29:0] bytes_mem [TRACK_DEPTH];
    logic [47:0] fence_mem [TRACK_DEPTH];
    cmd_t        cmd_reg;
    res_t        res_reg;
    logic [30:0] aligned_reg, padding_reg;
    logic        fits_reg;
    logic [CW-1:0] pos_reg;
    logic [47:0] next_fence_reg;
    logic [29:0] rd_bytes_reg;
    logic [47:0] rd_fence_reg;

    logic [30:0] amask, aligned_c, free_c, start_c, occ_c, end_c, batch_c;
    logic [AW-1:0] slot_c, tail_slot;
    logic [CW:0]   slot_sum, tail_sum;
    logic [47:0] nf;

    assign amask = ~((31'd1 << cmd_reg.align_log2) - 31'd1);
    assign aligned_c = ({1'b0, cursor_reg} + ~amask) & amask;
    assign free_c = (cap_reg > used_reg) ? {1'b0, cap_reg - used_reg} : '0;
    assign start_c = fits_reg ? aligned_reg : '0;
    assign occ_c = {1'b0, cmd_reg.size} + padding_reg;
    assign end_c = start_c + {1'b0, cmd_reg.size};
    assign batch_c = batch_reg + {1'b0, cmd_reg.size};
    // circular index, depth need not be a power of two
    assign slot_sum = (CW+1)'(head_reg) + (CW+1)'(pos_reg);
    assign tail_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign slot_c = (slot_sum >= (CW+1)'(TRACK_DEPTH)) ?
                    AW'(slot_sum - (CW+1)'(TRACK_DEPTH)) : AW'(slot_sum);
    assign tail_slot = (tail_sum >= (CW+1)'(TRACK_DEPTH)) ?
                       AW'(tail_sum - (CW+1)'(TRACK_DEPTH)) : AW'(tail_sum);
    assign nf = (fence_reg + 48'd1 == 48'd0) ? 48'd1 : fence_reg + 48'd1;

    assign q_ready = (state_reg == S_IDLE);
    assign r_valid = (state_reg == S_OUT);
    assign r_data  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cap_reg <= 30'd67108864;
            thr_reg <= 30'd8388608;
            cursor_reg <= '0;
            used_reg <= '0;
            batch_reg <= '0;
            fence_reg <= '0;
            head_reg <= '0;
            count_reg <= '0;
            unst_reg <= '0;
        end else begin
            if (cfg_we) begin
                if (!cfg_idx) cap_reg <= cfg_data;
                else          thr_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE: if (q_valid) begin
                    cmd_reg <= q_data;
                    res_reg.offset <= '0;
                    res_reg.occupied <= '0;
                    res_reg.stamped <= '0;
                    res_reg.used <= used_reg;
                    if (q_data.bad) begin
                        res_reg.status <= ST_INVALID;
                        state_reg <= S_OUT;
                    end else if (q_data.command == CMD_ALLOC) begin
                        if (count_reg >= CW'(TRACK_DEPTH) || q_data.size > cap_reg) begin
                            res_reg.status <= ST_NOROOM;
                            state_reg <= S_OUT;
                        end else begin
                            res_reg.status <= ST_OK;
                            state_reg <= S_CALC;
                        end
                    end else if (q_data.command == CMD_FLUSH) begin
                        res_reg.status <= ST_OK;
                        state_reg <= S_STAMP;
                        pos_reg <= count_reg - unst_reg;
                        next_fence_reg <= nf;
                    end else begin
                        res_reg.status <= ST_OK;
                        pos_reg <= '0;
                        state_reg <= S_RECL;
                    end
                end
                S_CALC: begin
                    aligned_reg <= aligned_c;
                    if (aligned_c <= {1'b0, cap_reg} &&
                        {1'b0, cmd_reg.size} <= {1'b0, cap_reg} - aligned_c) begin
                        fits_reg <= 1'b1;
                        padding_reg <= aligned_c - {1'b0, cursor_reg};
                    end else begin
                        fits_reg <= 1'b0;
                        padding_reg <= (cap_reg > cursor_reg) ?
                                       {1'b0, cap_reg - cursor_reg} : '0;
                    end
                    state_reg <= S_DEC;
                end
                S_DEC: begin
                    if (occ_c > free_c) begin
                        res_reg.status <= ST_NOROOM;
                        state_reg <= S_OUT;
                    end else begin
                        res_reg.offset <= start_c[28:0];
                        res_reg.occupied <= occ_c[29:0];
                        used_reg <= used_reg + occ_c[29:0];
                        res_reg.used <= used_reg + occ_c[29:0];
                        cursor_reg <= (end_c == {1'b0, cap_reg}) ? '0 : end_c[29:0];
                        bytes_mem[tail_slot] <= occ_c[29:0];
                        fence_mem[tail_slot] <= '0;
                        count_reg <= count_reg + 1'b1;
                        unst_reg <= unst_reg + 1'b1;
                        batch_reg <= batch_c;
                        pos_reg <= count_reg - unst_reg;
                        next_fence_reg <= nf;
                        state_reg <= (batch_c >= {1'b0, thr_reg}) ? S_STAMP : S_OUT;
                    end
                end
                S_STAMP: begin
                    // one entry per cycle until the batch is fully stamped
                    if (unst_reg == '0) state_reg <= S_OUT;
                    else if (pos_reg == count_reg) begin
                        fence_reg <= next_fence_reg;
                        res_reg.stamped <= next_fence_reg;
                        unst_reg <= '0;
                        batch_reg <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        fence_mem[slot_c] <= next_fence_reg;
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                S_RECL: begin
                    if (count_reg > unst_reg) begin
                        rd_bytes_reg <= bytes_mem[head_reg];
                        rd_fence_reg <= fence_mem[head_reg];
                        state_reg <= S_RDAT;
                    end else begin
                        res_reg.used <= used_reg;
                        state_reg <= S_OUT;
                    end
                end
                S_RDAT: begin
                    if (rd_fence_reg > cmd_reg.completed) begin
                        res_reg.used <= used_reg;
                        state_reg <= S_OUT;
                    end else begin
                        used_reg <= (used_reg >= rd_bytes_reg) ? used_reg - rd_bytes_reg : '0;
                        head_reg <= (head_reg == AW'(TRACK_DEPTH-1)) ? '0 : head_reg + 1'b1;
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_RECL;
                    end
                end
                S_OUT: if (r_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/fenced_ring_allocator.sv =====
// fenced_ring_allocator: top level, front classifier plus back executor
// depends on fra_pkg, fra_front, fra_back
// An allocate goes from queue head to result through alignment, fit check,
// commit and output; an automatic or explicit stamp walks the unstamped
// entries of the batch one at a time, and a completion report frees entries
// from the head one at a time until an entry with a later fence or an
// unstamped entry stops the walk, all set by the single-port tracking queue.
// A short command queue in front keeps accepting transactions, until full, while the back
// end works or its result waits. Tracking queue contents need no clearing.
module fenced_ring_allocator #(
    parameter int TRACK_DEPTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_idx,
    input  logic [29:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], request_size[31:2], align_log2[36:32], completed_fence[84:37]
    input  logic [87:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], grant_offset[30:2], occupied_bytes[60:31],
    // stamped_fence[108:61], used_total[138:109]
    output logic [143:0] m_tdata
);
    import fra_pkg::*;
    cmd_t q_data;
    res_t r_data;
    logic q_valid, q_ready;

    fra_front #(.QDEPTH(2)) u_front (
        .aclk, .aresetn,
        .s_valid(s_tvalid), .s_ready(s_tready),
        .command(s_tdata[1:0]), .request_size(s_tdata[31:2]),
        .align_log2(s_tdata[36:32]), .completed_fence(s_tdata[84:37]),
        .q_valid, .q_ready, .q_data
    );

    fra_back #(.TRACK_DEPTH(TRACK_DEPTH)) u_back (
        .aclk, .aresetn,
        .cfg_we, .cfg_idx(cfg_idx[0]), .cfg_data,
        .q_valid, .q_ready, .q_data,
        .r_valid(m_tvalid), .r_ready(m_tready), .r_data
    );

    assign m_tdata = {5'd0, r_data.used, r_data.stamped, r_data.occupied,
                      r_data.offset, r_data.status};
endmodule
